// ----- rtl/imu_frame_deframer_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the IMU frame deframer
// Concurrent assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef IMU_FRAME_DEFRAMER_MACROS_SVH
`define IMU_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge outside reset.
`define IFD_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define IFD_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define IFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define IFD_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define IFD_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define IFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- rtl/ifd_pkg.sv -----
// ----------------------------------------------------------------------------
// IMU frame deframer package
// Byte codes, frame geometry and shared types of the deframer.
// ----------------------------------------------------------------------------
package ifd_pkg;

	// Header and separator byte codes.
	localparam logic [7:0] CHAR_I     = 8'h69;
	localparam logic [7:0] CHAR_T     = 8'h74;
	localparam logic [7:0] CHAR_S     = 8'h73;
	localparam logic [7:0] CHAR_COLON = 8'h3A;

	// Frame geometry: 14 words of four data bytes, each but the last followed by a separator slot.
	localparam logic [3:0] LAST_WORD      = 4'd13;
	localparam logic [3:0] ACCEL_SEP_WORD = 4'd7;
	localparam logic [2:0] SUB_LAST_BYTE  = 3'd3;
	localparam logic [2:0] SUB_SEP        = 3'd4;

	// Output bus width: index, value and zero fill to whole bytes.
	localparam int M_TDATA_W = 40;

	// Frame phase, one-hot.
	typedef enum logic [3:0] {
		PH_I    = 4'b0001,
		PH_T    = 4'b0010,
		PH_S    = 4'b0100,
		PH_WORD = 4'b1000
	} phase_t;

	// One completed word.
	typedef struct packed {
		logic [3:0]  word_index;
		logic [31:0] word_value;
		logic        frame_last;
	} word_res_t;

endpackage

// ----- rtl/ifd_tracker.sv -----
// ----------------------------------------------------------------------------
// IMU frame deframer position tracker
// Follows the frame position byte by byte and assembles little-endian words.
// ----------------------------------------------------------------------------
`include "imu_frame_deframer_macros.svh"

module ifd_tracker
	import ifd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,      // consume rx_byte this cycle
	input  logic [7:0] rx_byte,
	output logic       emit,      // rx_byte completes a word
	output word_res_t  res
);

	phase_t      phase_q, phase_d;
	logic [3:0]  slot_q, slot_d;
	logic [2:0]  sub_q, sub_d;
	logic [23:0] word_bytes_q;

	// A word completes on its fourth byte.
	assign emit = (phase_q == PH_WORD) && (sub_q == SUB_LAST_BYTE);

	assign res.word_index = slot_q;
	assign res.word_value = {rx_byte, word_bytes_q};
	assign res.frame_last = (slot_q == LAST_WORD);

	// Next position of the frame.
	always_comb begin
		phase_d = phase_q;
		slot_d  = slot_q;
		sub_d   = sub_q;
		case (phase_q)
			PH_I: begin
				phase_d = (rx_byte == CHAR_I) ? PH_T : PH_I;
			end
			PH_T: begin
				phase_d = (rx_byte == CHAR_T) ? PH_S : PH_I;
			end
			PH_S: begin
				phase_d = (rx_byte == CHAR_S) ? PH_WORD : PH_I;
				slot_d  = 4'd0;
				sub_d   = 3'd0;
			end
			PH_WORD: begin
				if (sub_q == SUB_SEP) begin
					if (rx_byte == CHAR_COLON) begin
						slot_d = slot_q + 4'd1;
						sub_d  = 3'd0;
					end else if (slot_q == ACCEL_SEP_WORD && rx_byte == CHAR_I) begin
						phase_d = PH_T;
					end else begin
						phase_d = PH_I;
					end
				end else if (sub_q == SUB_LAST_BYTE && slot_q == LAST_WORD) begin
					phase_d = PH_I;
				end else begin
					sub_d = sub_q + 3'd1;
				end
			end
			default: begin
				phase_d = PH_I;
			end
		endcase
	end

	// Position registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_I;
			slot_q  <= 4'd0;
			sub_q   <= 3'd0;
		end else if (step) begin
			phase_q <= phase_d;
			slot_q  <= slot_d;
			sub_q   <= sub_d;
		end
	end

	// First three bytes of the current word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_bytes_q <= 24'd0;
		end else if (step && phase_q == PH_WORD) begin
			case (sub_q)
				3'd0:    word_bytes_q[7:0]   <= rx_byte;
				3'd1:    word_bytes_q[15:8]  <= rx_byte;
				3'd2:    word_bytes_q[23:16] <= rx_byte;
				default: word_bytes_q        <= word_bytes_q;
			endcase
		end
	end

	`IFD_ASSERT_SAME(a_slot_range, clk, arst_n, phase_q == PH_WORD, slot_q <= LAST_WORD, "word slot beyond last word")
	`IFD_ASSERT_SAME(a_sub_range, clk, arst_n, phase_q == PH_WORD, sub_q <= SUB_SEP, "sub position beyond separator")
	`IFD_ASSERT_NEXT(a_frame_end, clk, arst_n, step && emit && res.frame_last, phase_q == PH_I, "frame did not restart after last word")
	`IFD_ASSERT_NEXT(a_sep_follows, clk, arst_n, step && emit && !res.frame_last, sub_q == SUB_SEP, "separator slot skipped after word")

endmodule

// ----- rtl/imu_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// IMU frame deframer
// Streaming deframer that extracts the 14 raw 32-bit words of a sensor frame.
// ----------------------------------------------------------------------------
// Accepts one received byte per clock when the output does not stall; that
// sustained rate is set by the frame position update between the input register
// and the output register. A completed word is loaded into the output register
// once that register is free. A byte that completes a word waits in the input
// register while the output still holds an unaccepted word; all other bytes
// keep flowing during an output stall.
// A frame is the header "its", then 14 little-endian words with a ':' between
// neighbors; the final word is marked with m_tlast.
// Bytes that break the header or a separator send the deframer back to waiting
// for the header; an 'i' in the separator before the accel words counts as a
// new header start.
`include "imu_frame_deframer_macros.svh"

module imu_frame_deframer
	import ifd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] rx_byte
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [3:0] word_index, [35:4] word_value, zero fill
	output logic                 m_tlast    // frame_last
);

	logic      s1_valid_q;
	logic [7:0] rx_byte_s1;
	logic      out_valid_q;
	word_res_t out_q;
	word_res_t res;
	logic      emit;
	logic      out_free;
	logic      fire;

	// A byte that completes no word steps even while the output stalls.
	assign out_free = !out_valid_q || m_tready;
	assign fire     = s1_valid_q && (!emit || out_free);
	assign s_tready = !s1_valid_q || fire;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			s1_valid_q <= 1'b1;
		end else if (fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rx_byte_s1 <= s_tdata;
		end
	end

	ifd_tracker u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (fire),
		.rx_byte (rx_byte_s1),
		.emit    (emit),
		.res     (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_q.word_value, out_q.word_index};
	assign m_tlast  = out_q.frame_last;

	`IFD_ASSERT_NEXT(a_word_loaded, clk, arst_n, fire && emit, m_tvalid, "completed word did not reach the output")
	`IFD_ASSERT_NEXT(a_s1_held, clk, arst_n, s1_valid_q && !fire, s1_valid_q, "stalled byte dropped from input register")
	`IFD_ASSERT_SAME(a_last_index, clk, arst_n, m_tvalid && m_tlast, m_tdata[3:0] == LAST_WORD, "frame end flagged on a word other than the last")

endmodule

// ----- dv/imu_frame_deframer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU frame deframer testbench
// Streams header, separator and word bytes into the deframer and checks every
// emitted word against a byte-level model of the frame position tracker.
// ----------------------------------------------------------------------------
// The stimulus is mostly well-formed frames with random payload. The rest is
// frames cut short at a random byte that is corrupted, frames restarted by an
// 'i' in the separator before the accel words, and loose noise bytes.
// The sender works in bursts with random gaps. The receiver stalls on a
// rotating pattern. The sender also drains the output now and then.
module imu_frame_deframer_tb;
	import ifd_pkg::*;

	// Frame geometry.
	localparam int HDR_LEN       = 3;
	localparam int SLOT_LEN      = 5;
	localparam int FRAME_LEN     = 72;
	localparam int ACCEL_SEP_POS = HDR_LEN + ACCEL_SEP_WORD * SLOT_LEN + SUB_SEP;
	localparam int N_BYTES       = 1250;
	localparam int DRAIN_EVERY   = 400;
	localparam int IDLE_LIMIT    = 2000;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata  = 8'h00;   // [7:0] rx_byte
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;            // [3:0] word_index, [35:4] word_value, zero fill
	logic                 m_tlast;            // frame_last

	// Bytes waiting to be sent and words waiting to come out.
	logic [7:0]  rx_bytes_q[$];
	word_res_t   pending_words[$];

	// Model state of the frame tracker.
	logic [6:0]  frame_pos = '0;
	logic [23:0] word_acc  = '0;

	int err_cnt       = 0;
	int bytes_sent    = 0;
	int words_checked = 0;
	int frames_done   = 0;
	int restarts_sent = 0;
	int cuts_sent     = 0;
	int idle_cycles   = 0;

	imu_frame_deframer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	// Advance the frame tracker by one byte; queue a word when it completes.
	function automatic void deframe_byte(input logic [7:0] b);
		int        off;
		int        slot;
		int        sub_pos;
		logic [7:0] hdr_char;
		word_res_t w;
		if (frame_pos >= FRAME_LEN) begin
			frame_pos = '0;
		end else if (frame_pos < HDR_LEN) begin
			hdr_char = (frame_pos == 0) ? CHAR_I : (frame_pos == 1) ? CHAR_T : CHAR_S;
			frame_pos = (b == hdr_char) ? frame_pos + 7'd1 : 7'd0;
		end else begin
			off     = frame_pos - HDR_LEN;
			slot    = off / SLOT_LEN;
			sub_pos = off % SLOT_LEN;
			if (sub_pos == SUB_SEP) begin
				if (b == CHAR_COLON)
					frame_pos = frame_pos + 7'd1;
				else if (frame_pos == ACCEL_SEP_POS && b == CHAR_I)
					frame_pos = 7'd1;
				else
					frame_pos = 7'd0;
			end else if (sub_pos < SUB_LAST_BYTE) begin
				word_acc[8*sub_pos +: 8] = b;
				frame_pos = frame_pos + 7'd1;
			end else begin
				w.word_index = slot[3:0];
				w.word_value = {b, word_acc};
				w.frame_last = (slot == LAST_WORD);
				pending_words.push_back(w);
				frame_pos = (slot == LAST_WORD) ? 7'd0 : frame_pos + 7'd1;
			end
		end
	endfunction

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		err_cnt++;
	endtask

	// Correct bytes for frame positions lo..hi, with payload of varied style.
	task automatic push_frame_span(input int lo, input int hi);
		int p;
		int sub_pos;
		int style;
		style = 2;
		for (p = lo; p <= hi; p++) begin
			if (p == 0)
				rx_bytes_q.push_back(CHAR_I);
			else if (p == 1)
				rx_bytes_q.push_back(CHAR_T);
			else if (p == 2)
				rx_bytes_q.push_back(CHAR_S);
			else begin
				sub_pos = (p - HDR_LEN) % SLOT_LEN;
				if (sub_pos == SUB_SEP)
					rx_bytes_q.push_back(CHAR_COLON);
				else begin
					if (sub_pos == 0)
						style = $urandom_range(0, 5);
					case (style)
						0: rx_bytes_q.push_back(8'h00);
						1: rx_bytes_q.push_back(8'hFF);
						default: rx_bytes_q.push_back(8'($urandom_range(0, 255)));
					endcase
				end
			end
		end
	endtask

	// Stimulus, end of run and summary.
	initial begin : stimulus
		int  kind;
		int  cut;
		int  n;
		logic [7:0] bad;

		// Header mismatches, a mismatching 'i' that is not taken as a new start,
		// word extremes and separator mismatches.
		rx_bytes_q = '{CHAR_I, 8'h78, CHAR_I, CHAR_I, CHAR_T, CHAR_S, CHAR_T,
			CHAR_I, CHAR_T, CHAR_S, 8'h00, 8'hFF, 8'h00, 8'hFF, CHAR_I, CHAR_T, CHAR_S,
			CHAR_I, CHAR_T, CHAR_S, 8'h80, 8'h01, 8'hFE, 8'h7F, 8'h3B};

		// The first random sequence is an accel restart followed by a full frame.
		kind = 8;
		while (rx_bytes_q.size() < N_BYTES) begin
			if (kind < 5) begin
				push_frame_span(0, FRAME_LEN - 1);
			end else if (kind < 7) begin
				cut = $urandom_range(0, FRAME_LEN - 1);
				push_frame_span(0, cut - 1);
				push_frame_span(cut, cut);
				bad = rx_bytes_q.pop_back() ^ 8'($urandom_range(1, 255));
				rx_bytes_q.push_back(bad);
				cuts_sent++;
			end else if (kind < 9) begin
				push_frame_span(0, ACCEL_SEP_POS - 1);
				rx_bytes_q.push_back(CHAR_I);
				push_frame_span(1, FRAME_LEN - 1);
				restarts_sent++;
			end else begin
				n = $urandom_range(1, 8);
				repeat (n) rx_bytes_q.push_back(8'($urandom_range(0, 255)));
			end
			kind = $urandom_range(0, 9);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for all bytes to go out and all words to come back. The check runs
		// on the falling edge, after the clocked blocks have settled.
		do @(negedge clk);
		while (rx_bytes_q.size() != 0 || s_tvalid || pending_words.size() != 0);
		repeat (10) @(posedge clk);

		$display("Sent %0d bytes: %0d cut frames, %0d accel-separator restarts.",
			bytes_sent, cuts_sent, restarts_sent);
		$display("Checked %0d words, %0d complete frames.", words_checked, frames_done);
		if (err_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Byte driver: bursts with random gaps and an occasional full drain.
	always @(posedge clk or negedge arst_n) begin : driver
		int burst_left;
		int gap_left;
		bit draining;
		bit accepted;
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= 8'h00;
			burst_left = $urandom_range(1, 40);
			gap_left   = 0;
			draining   = 1'b0;
		end else begin
			accepted = s_tvalid && s_tready;
			if (accepted) begin
				deframe_byte(s_tdata);
				bytes_sent++;
				if (bytes_sent % DRAIN_EVERY == 0)
					draining = 1'b1;
			end
			if (draining && pending_words.size() == 0)
				draining = 1'b0;
			if (!s_tvalid || accepted) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (draining || rx_bytes_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata  <= rx_bytes_q.pop_front();
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end
				end
			end
		end
	end

	// Receiver stall pattern: the mode rotates with the upper two bits of an 8-bit counter.
	always @(posedge clk or negedge arst_n) begin : sink
		logic [7:0] stall_cnt;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			stall_cnt = '0;
		end else begin
			stall_cnt = stall_cnt + 8'd1;
			case (stall_cnt[7:6])
				2'd0: m_tready <= 1'b1;
				2'd1: m_tready <= 1'($urandom_range(0, 1));
				2'd2: m_tready <= (stall_cnt[1:0] == 2'd0);
				default: m_tready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// Word monitor: compare each output transaction with the oldest pending word.
	always @(posedge clk) begin : monitor
		word_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word index %0d value %08h last %0b",
					m_tdata[3:0], m_tdata[35:4], m_tlast));
			end else begin
				want = pending_words.pop_front();
				if (m_tdata[3:0] != want.word_index)
					report_mismatch($sformatf("word_index got %0d want %0d",
						m_tdata[3:0], want.word_index));
				if (m_tdata[35:4] != want.word_value)
					report_mismatch($sformatf("word_value got %08h want %08h (index %0d)",
						m_tdata[35:4], want.word_value, want.word_index));
				if (m_tlast != want.frame_last)
					report_mismatch($sformatf("frame_last got %0b want %0b (index %0d)",
						m_tlast, want.frame_last, want.word_index));
				words_checked++;
				if (want.frame_last)
					frames_done++;
			end
		end
	end

	// Watchdog: too many cycles without any transaction ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles.", IDLE_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

endmodule
